// ===== rtl/sensor_frame_receiver_resync_unit_assert.svh =====
// Assertion macros used by the checker file of the frame receiver.
// Every macro samples on the rising edge of i_clk and is held off while i_rst_n is low.
`ifndef SENSOR_FRAME_RECEIVER_RESYNC_UNIT_ASSERT_SVH
`define SENSOR_FRAME_RECEIVER_RESYNC_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // Byte that opens a frame, and that marks a resync point after a checksum failure.
    localparam logic [7:0] HEADER_BYTE = 8'hFF;

    // Width of the word index field on the output.
    localparam int WIDX_W = 4;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SUM      = 6'b000010,
        ST_COPY     = 6'b000100,
        ST_EMIT_HI  = 6'b001000,
        ST_EMIT_LO  = 6'b010000,
        ST_EMIT_OUT = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sfr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port and one read port with a registered read.
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 29,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold the read data while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sensor_frame_receiver_resync_unit.sv =====
// Serial frame receiver with header resynchronisation. Bytes enter one word at a
// time on i_rx_byte. While hunting, every byte is dropped until the header 0xFF
// arrives. After it, PAYLOAD_BYTES payload bytes and one checksum byte are
// collected into a small RAM. The checksum is the 8-bit wrapping sum of the
// payload. A good frame leaves as PAYLOAD_BYTES/2 big-endian 16-bit words with
// their index, and the last one is flagged by o_last_word. An odd final payload
// byte enters the sum but is not sent. On a bad checksum, the bytes after the
// first 0xFF held in the frame (payload or checksum) are kept as the start of the
// next frame body. If no 0xFF is held, the block goes back to hunting.
// Flow: a byte that does not complete a frame is taken at once, so such bytes
// may arrive back to back. The byte that completes a frame starts one sweep
// through the RAM, one entry per cycle. That sweep forms the sum and finds the
// first 0xFF. A good frame then reads the two bytes of each word through the
// single read port in the states EMIT_HI, EMIT_LO and EMIT_OUT, and waits in
// EMIT_OUT while the output is stalled. A bad frame that keeps bytes then moves
// them down to the bottom of the RAM. While the sweep, the emission or the move
// runs, o_in_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_receiver_resync_unit
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 28
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // byte input channel
    input  wire logic              i_in_valid,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_in_stall,
    // word output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [15:0]       o_word_value,
    output logic      [WIDX_W-1:0] o_word_index,
    output logic                   o_last_word
);

    localparam int FRAME_BYTES = PAYLOAD_BYTES + 1;
    localparam int WORD_COUNT  = PAYLOAD_BYTES / 2;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int K_W         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // sequencer and frame state
    t_state            r_state,     n_state;
    logic              r_in_frame,  n_in_frame;
    logic [FILL_W-1:0] r_fill,      n_fill;
    // sweep engine: read issue counter, read data valid, index of that data
    logic [FILL_W-1:0] r_cnt,       n_cnt;
    logic              r_dv,        n_dv;
    logic [ADDR_W-1:0] r_didx,      n_didx;
    logic [7:0]        r_sum,       n_sum;
    logic              r_ff_found,  n_ff_found;
    logic [ADDR_W-1:0] r_ff_pos,    n_ff_pos;
    logic [ADDR_W-1:0] r_wa,        n_wa;
    // emission
    logic [K_W-1:0]    r_k,         n_k;
    logic [7:0]        r_hi,        n_hi;
    // output register
    logic              r_out_valid;
    logic [15:0]       r_out_value;
    logic [K_W-1:0]    r_out_idx;
    logic              r_out_last;
    logic              out_load;
    logic              out_free;

    // RAM port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wa;
    logic [7:0]        ram_wd;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_ra;
    logic [7:0]        ram_rd;

    // resync decision on the checksum byte
    logic              hit_ff;
    logic              found_now;
    logic [ADDR_W-1:0] pos_now;
    logic [FILL_W-1:0] keep;
    logic              last_k;

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    // The first 0xFF may be the byte on the read port right now.
    assign hit_ff    = (ram_rd == HEADER_BYTE);
    assign found_now = r_ff_found | hit_ff;
    assign pos_now   = r_ff_found ? r_ff_pos : r_didx;
    assign keep      = FILL_W'(FRAME_BYTES - 1) - FILL_W'(pos_now);
    assign last_k    = (r_k == K_W'(WORD_COUNT - 1));
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        n_in_frame = r_in_frame;
        n_fill     = r_fill;
        n_cnt      = r_cnt;
        n_dv       = r_dv;
        n_didx     = r_didx;
        n_sum      = r_sum;
        n_ff_found = r_ff_found;
        n_ff_pos   = r_ff_pos;
        n_wa       = r_wa;
        n_k        = r_k;
        n_hi       = r_hi;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_wa     = r_fill[ADDR_W-1:0];
        ram_wd     = i_rx_byte;
        ram_re     = 1'b0;
        ram_ra     = r_cnt[ADDR_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (!r_in_frame) begin
                        // hunt: drop everything but the header
                        if (i_rx_byte == HEADER_BYTE) begin
                            n_in_frame = 1'b1;
                            n_fill     = '0;
                        end
                    end else begin
                        // store the body byte at the fill position
                        ram_we = 1'b1;
                        n_fill = r_fill + 1'b1;
                        if (r_fill == FILL_W'(FRAME_BYTES - 1)) begin
                            n_state    = ST_SUM;
                            n_cnt      = '0;
                            n_dv       = 1'b0;
                            n_sum      = '0;
                            n_ff_found = 1'b0;
                        end
                    end
                end
            end

            ST_SUM: begin
                // issue one read per cycle over the whole frame
                if (r_cnt < FILL_W'(FRAME_BYTES)) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_dv   = 1'b1;
                    n_didx = r_cnt[ADDR_W-1:0];
                end else begin
                    n_dv = 1'b0;
                end
                // accumulate the sum and note the first header byte
                if (r_dv) begin
                    if (!r_ff_found && hit_ff) begin
                        n_ff_found = 1'b1;
                        n_ff_pos   = r_didx;
                    end
                    if (r_didx < ADDR_W'(PAYLOAD_BYTES)) begin
                        n_sum = r_sum + ram_rd;
                    end else begin
                        n_dv = 1'b0;
                        if (r_sum == ram_rd) begin
                            n_state = ST_EMIT_HI;
                            n_k     = '0;
                        end else if (!found_now) begin
                            n_state    = ST_IDLE;
                            n_in_frame = 1'b0;
                            n_fill     = '0;
                        end else if (pos_now == ADDR_W'(FRAME_BYTES - 1)) begin
                            n_state = ST_IDLE;
                            n_fill  = '0;
                        end else begin
                            n_state = ST_COPY;
                            n_cnt   = FILL_W'(pos_now) + 1'b1;
                            n_wa    = '0;
                            n_fill  = keep;
                        end
                    end
                end
            end

            ST_COPY: begin
                // move the bytes after the header down to the bottom
                if (r_cnt < FILL_W'(FRAME_BYTES)) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_dv   = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    ram_we = 1'b1;
                    ram_wa = r_wa;
                    ram_wd = ram_rd;
                    n_wa   = r_wa + 1'b1;
                    if (r_cnt == FILL_W'(FRAME_BYTES)) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_EMIT_HI: begin
                ram_re  = 1'b1;
                ram_ra  = ADDR_W'({r_k, 1'b0});
                n_state = ST_EMIT_LO;
            end

            ST_EMIT_LO: begin
                n_hi    = ram_rd;
                ram_re  = 1'b1;
                ram_ra  = ADDR_W'({r_k, 1'b1});
                n_state = ST_EMIT_OUT;
            end

            ST_EMIT_OUT: begin
                // hold the low byte on the read port until the output register frees
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_k) begin
                        n_state    = ST_IDLE;
                        n_in_frame = 1'b0;
                        n_fill     = '0;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_EMIT_HI;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_frame  <= 1'b0;
            r_fill      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_fill     <= n_fill;
            r_dv       <= n_dv;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, set on entry to each phase
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_didx     <= n_didx;
        r_sum      <= n_sum;
        r_ff_found <= n_ff_found;
        r_ff_pos   <= n_ff_pos;
        r_wa       <= n_wa;
        r_k        <= n_k;
        r_hi       <= n_hi;
        if (out_load) begin
            r_out_value <= {r_hi, ram_rd};
            r_out_idx   <= r_k;
            r_out_last  <= last_k;
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_word_value = r_out_value;
    assign o_word_index = WIDX_W'(r_out_idx);
    assign o_last_word  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/sfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "sensor_frame_receiver_resync_unit_assert.svh"

module sfr_checker
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 28
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [15:0]       o_word_value,
    input wire logic [WIDX_W-1:0] o_word_index,
    input wire logic              o_last_word
);

    localparam int WORD_COUNT = PAYLOAD_BYTES / 2;

    // hold a stalled word
    `SFR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_word_value) && $stable(o_word_index) && $stable(o_last_word), "stalled output word changed")

    // flag the last word only at the final index
    `SFR_ASSERT_SAME(a_last_index, o_out_valid && o_last_word, o_word_index == WIDX_W'(WORD_COUNT - 1), "last word flagged at wrong index")

    // keep the input stalled while a frame is still being sent
    `SFR_ASSERT_SAME(a_busy_emit, o_out_valid && !o_last_word, o_in_stall, "input open in mid-frame")

    // once the input is open, a word taken is not followed at once by another
    `SFR_ASSERT_NEXT(a_word_gap, o_out_valid && !i_out_stall && !o_in_stall, !o_out_valid, "word repeated or emitted too soon")

endmodule

bind sensor_frame_receiver_resync_unit sfr_checker #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_sfr_checker (.*);

`default_nettype wire

// ===== bench/tb_sensor_frame_receiver_resync_unit.sv =====
`timescale 1ns / 1ps

module tb_sensor_frame_receiver_resync_unit;
    import sfr_pkg::*;

    localparam int PAYLOAD_LEN = 28;
    localparam int FRAME_LEN   = PAYLOAD_LEN + 1;
    localparam int WORD_TOTAL  = PAYLOAD_LEN / 2;
    // Length of the forced output back-pressure, long enough to fill the block.
    localparam int HOLD_CYCLES = 400;
    // Run limit for the watchdog, which reports a mismatch when it runs out.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 35;

    // One expected payload word on the output channel.
    typedef struct packed {
        logic [15:0]       value;
        logic [WIDX_W-1:0] index;
        logic              last;
    } payload_word_t;

    // Predicts the output words from the accepted input bytes and checks them in order.
    class frame_word_tracker;
        payload_word_t pending_words[$];
        logic [7:0]    held_bytes[FRAME_LEN];
        int            held_count;
        bit            collecting;
        int            body_bytes;
        int            fails;

        function new();
            held_count = 0;
            collecting = 1'b0;
            body_bytes = 0;
            fails      = 0;
        endfunction

        // Note one accepted input word (a received byte) and queue any payload words it releases.
        function void take_byte(logic [7:0] b);
            logic [7:0]    sum;
            payload_word_t w;
            int            i;
            int            hdr;
            int            keep;
            if (!collecting) begin
                // Hunting: drop everything but the header.
                if (b == HEADER_BYTE) begin
                    collecting = 1'b1;
                    held_count = 0;
                    body_bytes++;
                end
                return;
            end
            body_bytes++;
            if (held_count >= FRAME_LEN)
                held_count = 0;
            held_bytes[held_count] = b;
            held_count++;
            if (held_count < FRAME_LEN)
                return;

            sum = 8'h00;
            for (i = 0; i < PAYLOAD_LEN; i++)
                sum += held_bytes[i];

            if (sum != held_bytes[PAYLOAD_LEN]) begin
                // Bad checksum: restart just after the first header held, if any.
                hdr = -1;
                for (i = 0; i < FRAME_LEN; i++)
                    if (hdr < 0 && held_bytes[i] == HEADER_BYTE)
                        hdr = i;
                if (hdr < 0) begin
                    held_count = 0;
                    collecting = 1'b0;
                end else begin
                    keep = FRAME_LEN - hdr - 1;
                    for (i = 0; i < keep; i++)
                        held_bytes[i] = held_bytes[hdr + 1 + i];
                    held_count = keep;
                    collecting = 1'b1;
                end
                return;
            end

            for (i = 0; i < WORD_TOTAL; i++) begin
                w.value = {held_bytes[2 * i], held_bytes[2 * i + 1]};
                w.index = WIDX_W'(i);
                w.last  = (i == WORD_TOTAL - 1);
                pending_words.push_back(w);
            end
            held_count = 0;
            collecting = 1'b0;
        endfunction

        // Compare one accepted output word with the oldest expectation.
        function void check_word(logic [15:0] value, logic [WIDX_W-1:0] index, logic last);
            payload_word_t want;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual value %h index %0d last %b",
                         $time, value, index, last);
                fails++;
                return;
            end
            want = pending_words.pop_front();
            if (value !== want.value) begin
                $display("%0t: word_value expected %h actual %h", $time, want.value, value);
                fails++;
            end
            if (index !== want.index) begin
                $display("%0t: word_index expected %0d actual %0d", $time, want.index, index);
                fails++;
            end
            if (last !== want.last) begin
                $display("%0t: last_word expected %b actual %b", $time, want.last, last);
                fails++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic [7:0]        i_rx_byte;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [15:0]       o_word_value;
    logic [WIDX_W-1:0] o_word_index;
    logic              o_last_word;

    frame_word_tracker tracker;

    // Idle rates in percent for each side, and the request for a long output hold.
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;

    // Scratch frame: 28 payload bytes and the checksum byte.
    logic [7:0] frame_body[FRAME_LEN];

    sensor_frame_receiver_resync_unit #(
        .PAYLOAD_BYTES(PAYLOAD_LEN)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_word_value (o_word_value),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one input word, with random idle cycles first; hold it until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_rx_byte  <= 8'($urandom);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_byte(b);
    endtask

    // Draw a payload byte, weighted towards the extremes; keep clear of the header if asked.
    function automatic logic [7:0] pick_data(bit allow_header);
        case ($urandom_range(7))
            0: pick_data = 8'h00;
            1: pick_data = allow_header ? HEADER_BYTE : 8'hFE;
            2: pick_data = 8'h80;
            3: pick_data = 8'h7F;
            default: pick_data = allow_header ? 8'($urandom_range(255)) : 8'($urandom_range(254));
        endcase
    endfunction

    function automatic void fill_body(bit allow_header);
        int i;
        for (i = 0; i < PAYLOAD_LEN; i++)
            frame_body[i] = pick_data(allow_header);
    endfunction

    function automatic logic [7:0] payload_sum();
        logic [7:0] sum;
        int         i;
        sum = 8'h00;
        for (i = 0; i < PAYLOAD_LEN; i++)
            sum += frame_body[i];
        return sum;
    endfunction

    task automatic send_body(input int first, input int count);
        int i;
        for (i = 0; i < count; i++)
            send_byte(frame_body[first + i]);
    endtask

    // A well-formed frame; the header may be left off when the block is already in a frame.
    task automatic send_good_frame(input bit with_header);
        fill_body(1'b1);
        frame_body[PAYLOAD_LEN] = payload_sum();
        if (with_header)
            send_byte(HEADER_BYTE);
        send_body(0, FRAME_LEN);
    endtask

    // A frame with a bad checksum and no header in its payload. With header_last the
    // checksum byte itself is the header, so the block stays in a frame with nothing kept;
    // otherwise it falls back to hunting.
    task automatic send_dead_frame(input bit header_last);
        logic [7:0] sum;
        fill_body(1'b0);
        if (header_last) begin
            // Nudge the sum off 0xFF without creating a header byte.
            if (payload_sum() == HEADER_BYTE)
                frame_body[0] = (frame_body[0] == 8'h00) ? 8'h01 : frame_body[0] - 8'h01;
            frame_body[PAYLOAD_LEN] = HEADER_BYTE;
        end else begin
            sum = payload_sum() + 8'h01;
            frame_body[PAYLOAD_LEN] = (sum == HEADER_BYTE) ? sum + 8'h01 : sum;
        end
        send_byte(HEADER_BYTE);
        send_body(0, FRAME_LEN);
    endtask

    // A corrupt frame whose first header sits at position at; the bytes after it open a
    // good frame, and the rest of that frame follows with no fresh header.
    task automatic send_resync_frame(input int at);
        logic [7:0] tail[FRAME_LEN];
        int         i;
        fill_body(1'b1);
        frame_body[PAYLOAD_LEN] = payload_sum();
        for (i = 0; i < FRAME_LEN; i++)
            tail[i] = frame_body[i];
        fill_body(1'b0);
        frame_body[at] = HEADER_BYTE;
        for (i = at + 1; i < FRAME_LEN; i++)
            frame_body[i] = tail[i - at - 1];
        send_byte(HEADER_BYTE);
        send_body(0, FRAME_LEN);
        for (i = 0; i < FRAME_LEN; i++)
            frame_body[i] = tail[i];
        send_body(PAYLOAD_LEN - at, at + 1);
    endtask

    // Output side: stall at random or for a long hold, and check every word taken.
    initial begin : receiver
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            // The hold is counted here, independent of the sender.
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                tracker.check_word(o_word_value, o_word_index, o_last_word);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("sensor_frame_receiver_resync_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        int goal;
        int phase;
        int pick;
        int i;
        tracker       = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = 8'h00;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Drop two non-header bytes while hunting.
        send_byte(8'h00);
        send_byte(8'hFE);

        // Good frame of extreme bytes, headers inside the body taken as data;
        // first word 0x0000, last word 0xFFFF.
        for (i = 0; i < PAYLOAD_LEN; i++) begin
            case (i % 4)
                0: frame_body[i] = 8'h00;
                1: frame_body[i] = HEADER_BYTE;
                2: frame_body[i] = 8'h80;
                default: frame_body[i] = 8'h7F;
            endcase
        end
        frame_body[1]               = 8'h00;
        frame_body[PAYLOAD_LEN - 2] = HEADER_BYTE;
        frame_body[PAYLOAD_LEN - 1] = HEADER_BYTE;
        frame_body[PAYLOAD_LEN]     = payload_sum();
        send_byte(HEADER_BYTE);
        send_body(0, FRAME_LEN);

        // Bad checksum with no header held: back to hunting.
        send_dead_frame(1'b0);
        // Header as the checksum byte: nothing kept, the next frame needs no header.
        send_dead_frame(1'b1);
        send_good_frame(1'b0);
        // Resync from a header in the middle, and from the very first payload byte.
        send_resync_frame(10);
        send_resync_frame(0);

        // Random part in three idling phases; the first opens with a long output hold
        // and a good frame while the sender keeps offering words, so the block fills
        // and stalls its input.
        goal = tracker.body_bytes;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 56;
                    hold_req      = 1'b1;
                    send_good_frame(1'b1);
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            goal += PHASE_BYTES;
            while (tracker.body_bytes < goal) begin
                pick = $urandom_range(9);
                if (pick < 6) begin
                    send_good_frame(1'b1);
                end else if (pick < 8) begin
                    send_resync_frame($urandom_range(PAYLOAD_LEN));
                end else if (pick == 8) begin
                    send_dead_frame($urandom_range(1));
                end else begin
                    // Line noise, sometimes followed by a truncated frame.
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(254)));
                    if ($urandom_range(1)) begin
                        send_byte(HEADER_BYTE);
                        repeat ($urandom_range(1, 20)) send_byte(pick_data(1'b1));
                    end
                end
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain the expected words, then allow for a resync move still running.
        while (tracker.pending_words.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (tracker.fails == 0)
            $display("sensor_frame_receiver_resync_unit: match");
        else
            $display("sensor_frame_receiver_resync_unit: mismatch");
        $finish;
    end

endmodule

// ===== sensor_frame_receiver_resync_unit.f =====
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_ram.sv
rtl/sensor_frame_receiver_resync_unit.sv
rtl/sfr_checker.sv
bench/tb_sensor_frame_receiver_resync_unit.sv
